// File: hdl/lad_pkg.sv
package lad_pkg;

    localparam int LINE_BYTES_W = 14;
    localparam int FRAME_LINES_W = 13;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_INDEX_W = 2;

    localparam logic [LINE_BYTES_W-1:0] LINE_BYTES_RESET = LINE_BYTES_W'(3840);
    localparam logic [FRAME_LINES_W-1:0] FRAME_LINES_RESET = FRAME_LINES_W'(1080);

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LINES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEINTERLACE_ON = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_item_t;

    // Where the result byte of an item comes from.
    typedef enum logic [1:0] {
        SRC_PIXEL,
        SRC_STORE,
        SRC_AVERAGE
    } byte_src_t;

endpackage

// File: hdl/lad_line_store.sv
module lad_line_store #(
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // A read that meets a write to the same entry takes the new byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : q_reg;

endmodule

// File: hdl/line_average_deinterlacer.sv
// Line-averaging deinterlacer. Takes one frame byte (or one flush item) per clock in raster
// order and gives one deinterlaced byte per clock unless m_ready stalls it, one line behind the
// input: even lines pass, inner odd lines become the truncated average of the even lines around
// them, and with an even height the last odd line repeats the line above it. The held last line
// of a frame leaves while the next frame's first line arrives, or one byte per flush item. Each
// accepted item is held in stage two, which gets the line store read issued at the accepting
// edge and forms the blend from the registered read data, and then enters the output register.
// The sustained rate is one item per clock unless m_ready stalls. Configuration must be written
// by the user through cfg_we/cfg_index/cfg_wdata while idle; the block does not enforce this.
module line_average_deinterlacer #(
    parameter int MAX_LINE_BYTES = 8192,
    parameter int MAX_LINES = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lad_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lad_pkg::out_item_t           m_data,
    input  logic                         cfg_we,
    input  logic [lad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lad_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW = $clog2(MAX_LINE_BYTES);
    localparam int LW = $clog2(MAX_LINES);
    localparam int CCMP_W = (CW + 1 > lad_pkg::LINE_BYTES_W) ? CW + 1 : lad_pkg::LINE_BYTES_W;
    localparam int LCMP_W = (LW + 1 > lad_pkg::FRAME_LINES_W) ? LW + 1 : lad_pkg::FRAME_LINES_W;

    // Configuration.
    logic [lad_pkg::LINE_BYTES_W-1:0]  line_bytes_reg;
    logic [lad_pkg::FRAME_LINES_W-1:0] frame_lines_reg;
    logic                              deinterlace_on_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_bytes_reg <= lad_pkg::LINE_BYTES_RESET;
            frame_lines_reg <= lad_pkg::FRAME_LINES_RESET;
            deinterlace_on_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lad_pkg::REG_LINE_BYTES: begin
                    line_bytes_reg <= cfg_wdata[lad_pkg::LINE_BYTES_W-1:0];
                end
                lad_pkg::REG_FRAME_LINES: begin
                    frame_lines_reg <= cfg_wdata[lad_pkg::FRAME_LINES_W-1:0];
                end
                lad_pkg::REG_DEINTERLACE_ON: begin
                    deinterlace_on_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front stage: counters and the decision for each item.
    logic [CW-1:0] column_reg, column_next;
    logic [LW-1:0] line_reg, line_next;
    logic          held_reg, held_next;

    logic [CCMP_W-1:0] column_plus;
    logic [LCMP_W-1:0] line_plus;
    logic              line_end;
    logic              frame_last;
    logic              s_accept;

    logic          emit;
    logic          store_wr;
    logic          store_rd;
    logic          frame_end;
    lad_pkg::byte_src_t src;
    logic          advance;

    // Stage two and output register.
    logic                 p2_valid_reg;
    logic                 p2_emit_reg;
    logic                 p2_wr_reg;
    logic                 p2_frame_end_reg;
    lad_pkg::byte_src_t   p2_src_reg;
    logic [7:0]           p2_pixel_reg;
    logic [CW-1:0]        p2_addr_reg;
    logic                 p2_adv;
    logic [7:0]           store_q;
    logic [8:0]           pair_sum;
    logic [7:0]           result_byte;
    logic                 m_valid_reg;
    lad_pkg::out_item_t   m_data_reg;

    // A zero register acts as one and never exceeds the maximum, so compare with both.
    assign column_plus = CCMP_W'(column_reg) + CCMP_W'(1);
    assign line_plus = LCMP_W'(line_reg) + LCMP_W'(1);
    assign line_end = (column_plus >= CCMP_W'(line_bytes_reg))
                   || (column_plus >= CCMP_W'(MAX_LINE_BYTES));
    assign frame_last = (line_plus >= LCMP_W'(frame_lines_reg))
                     || (line_plus >= LCMP_W'(MAX_LINES));

    assign p2_adv = p2_valid_reg && !(p2_emit_reg && m_valid_reg && !m_ready);
    assign s_ready = !p2_valid_reg || p2_adv;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        emit = 1'b0;
        store_wr = 1'b0;
        store_rd = 1'b0;
        frame_end = 1'b0;
        src = lad_pkg::SRC_PIXEL;
        advance = 1'b1;
        if (s_data.op == lad_pkg::OP_FLUSH) begin
            advance = deinterlace_on_reg && held_reg;
            emit = advance;
            store_rd = advance;
            src = lad_pkg::SRC_STORE;
            frame_end = line_end;
        end else if (!deinterlace_on_reg) begin
            emit = 1'b1;
            frame_end = line_end && frame_last;
        end else if (line_reg == '0) begin
            emit = held_reg;
            store_rd = held_reg;
            store_wr = 1'b1;
            src = lad_pkg::SRC_STORE;
            frame_end = line_end;
        end else if (line_reg[0]) begin
            emit = 1'b1;
            store_rd = 1'b1;
            src = lad_pkg::SRC_STORE;
        end else begin
            emit = 1'b1;
            store_rd = 1'b1;
            store_wr = 1'b1;
            src = lad_pkg::SRC_AVERAGE;
        end
    end

    always_comb begin
        column_next = column_reg;
        line_next = line_reg;
        held_next = held_reg;
        if (s_accept && advance) begin
            column_next = line_end ? '0 : column_plus[CW-1:0];
            if (s_data.op == lad_pkg::OP_FLUSH) begin
                if (line_end) begin
                    held_next = 1'b0;
                end
            end else begin
                if (!deinterlace_on_reg || (line_reg == '0 && line_end)) begin
                    held_next = 1'b0;
                end
                if (line_end) begin
                    if (frame_last) begin
                        line_next = '0;
                        if (deinterlace_on_reg) begin
                            held_next = 1'b1;
                        end
                    end else begin
                        line_next = line_plus[LW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            line_reg <= '0;
            held_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            column_reg <= column_next;
            line_reg <= line_next;
            held_reg <= held_next;
            if (s_accept) begin
                p2_valid_reg <= 1'b1;
            end else if (p2_adv) begin
                p2_valid_reg <= 1'b0;
            end
            if (p2_adv && p2_emit_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p2_emit_reg <= emit;
            p2_wr_reg <= store_wr;
            p2_frame_end_reg <= frame_end;
            p2_src_reg <= src;
            p2_pixel_reg <= s_data.pixel_byte;
            p2_addr_reg <= column_reg;
        end
        if (p2_adv && p2_emit_reg) begin
            m_data_reg.out_byte <= result_byte;
            m_data_reg.frame_end <= p2_frame_end_reg;
        end
    end

    // The write of stage two lands when it moves on; a read of the same entry
    // in that cycle is forwarded inside the store.
    lad_line_store #(
        .DEPTH(MAX_LINE_BYTES)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept && store_rd),
        .rd_addr (column_reg),
        .wr_en   (p2_adv && p2_wr_reg),
        .wr_addr (p2_addr_reg),
        .wr_data (p2_pixel_reg),
        .rd_data (store_q)
    );

    assign pair_sum = {1'b0, store_q} + {1'b0, p2_pixel_reg};

    always_comb begin
        case (p2_src_reg)
            lad_pkg::SRC_STORE:   result_byte = store_q;
            lad_pkg::SRC_AVERAGE: result_byte = pair_sum[8:1];
            default:              result_byte = p2_pixel_reg;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule
